### rtl/deqr_pkg.sv
// Shared constants, request codes and cell command type for the deque.
// Used by the channel interfaces, the cell, the top level and the checker.
// No dependencies.
package deqr_pkg;

   // Capacity and stored word width
   localparam int DEPTH       = 64;
   localparam int VALUE_WIDTH = 64;

   // Widths of the item fields
   localparam int REQ_TYPE_W    = 3;
   localparam int FIELD_W       = 64;
   localparam int ENTRY_COUNT_W = 7;

   // Internal fill count must hold DEPTH itself
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_REVERSE    = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY      = 3'd5;

   // One command broadcast to every cell of the row
   typedef struct packed {
      logic shift_in;    // take the left neighbour's word (insert at physical start)
      logic shift_out;   // take the right neighbour's word (remove physical first)
      logic write_tail;  // first empty cell stores the pushed word
      logic drop_tail;   // last occupied cell empties
   } cell_cmd_type;

endpackage

### rtl/deqr_if.sv
// Valid/ready channel interfaces for the deque: request channel and result channel.
// Depends on deqr_pkg for field widths.
interface deqr_req_if import deqr_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [FIELD_W-1:0]      push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deqr_rsp_if import deqr_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [FIELD_W-1:0]         front_value;
   logic [FIELD_W-1:0]         back_value;
   logic [ENTRY_COUNT_W-1:0]   entry_count;
   logic                       is_empty;
   logic                       op_error;

   modport source (output valid, output front_value, output back_value,
                   output entry_count, output is_empty, output op_error, input ready);
   modport sink   (input valid, input front_value, input back_value,
                   input entry_count, input is_empty, input op_error, output ready);
endinterface

### rtl/deqr_cell.sv
// One storage cell of the deque row: a word and an occupied bit, shifting to
// either neighbour on command. Depends on deqr_pkg.
module deqr_cell import deqr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_cmd_type           cmd,
   input  logic [VALUE_WIDTH-1:0] push_word,
   input  logic [VALUE_WIDTH-1:0] left_value,
   input  logic                   left_valid,
   input  logic [VALUE_WIDTH-1:0] right_value,
   input  logic                   right_valid,
   output logic [VALUE_WIDTH-1:0] cell_value,
   output logic                   cell_valid,
   output logic [VALUE_WIDTH-1:0] back_part
);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   is_tail_slot;
   logic                   is_last;

   // Locate the ends of the occupied run from the neighbours
   assign is_tail_slot = !valid_ff && left_valid;
   assign is_last      = valid_ff && !right_valid;

   // Select the next word and occupied bit
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.shift_in) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (cmd.shift_out) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (cmd.write_tail && is_tail_slot) begin
         value_in = push_word;
         valid_in = 1'b1;
      end else if (cmd.drop_tail && is_last) begin
         valid_in = 1'b0;
      end
   end

   // Clear the occupied bit under reset; the word needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
   assign cell_valid = valid_ff;
   // Offer the word to the back-value reduction only from the last occupied cell
   assign back_part  = is_last ? value_ff : '0;

endmodule

### rtl/double_ended_queue_with_reverse.sv
// Bounded double-ended queue of DEPTH words with push/pop at either end, reverse
// and query. Built from deqr_cell, deqr_pkg and the deqr_req_if/deqr_rsp_if channels.
//
// The words sit in a row of DEPTH cells, physical first word in cell 0, the
// occupied cells forming one run from cell 0. Pushing at the physical start and
// popping from it shift the whole row by one cell at once; the other end is
// written or emptied in place. Reverse only toggles a direction flag that swaps
// the meaning of front and back. One request item is accepted per clock cycle
// while the result side keeps up. The row and counters take the request at the
// accepting edge; the result stage then loads from cell 0 and from an OR
// reduction over the last-occupied markers of the row, once the result side is
// free, so a result item reflects the row and counters after its request.
// A stalled result holds the request side after at most one further item.
// A pop on an empty queue or a push on a full one raises op_error and changes
// nothing. front_value and back_value read zero when the queue is empty.
module double_ended_queue_with_reverse import deqr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   deqr_req_if.sink   req_chan,
   deqr_rsp_if.source rsp_chan
);

   // Cell row
   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic                   cell_valid [DEPTH];
   logic [VALUE_WIDTH-1:0] back_part  [DEPTH];
   logic [VALUE_WIDTH-1:0] push_word;
   cell_cmd_type           cmd;

   // Control state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rev_ff, rev_in;
   logic               pend_ff, pend_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Result payload
   logic [FIELD_W-1:0]       front_ff, back_ff;
   logic [ENTRY_COUNT_W-1:0] entry_ff;
   logic                     empty_ff;
   logic                     op_err_ff;

   logic                   accept;
   logic                   rsp_free;
   logic                   load;
   logic                   is_full;
   logic                   is_empty_now;
   logic                   at_first;
   logic [VALUE_WIDTH-1:0] first_word;
   logic [VALUE_WIDTH-1:0] last_word;

   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign load      = pend_ff && rsp_free;
   assign req_chan.ready = !pend_ff || rsp_free;
   assign accept    = req_chan.valid && req_chan.ready;
   assign push_word = VALUE_WIDTH'(req_chan.push_value);

   assign is_full      = (count_ff == COUNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);

   // Decode the request into a row command and the new counters
   always_comb begin
      cmd      = '0;
      count_in = count_ff;
      rev_in   = rev_ff;
      err_in   = err_ff;
      at_first = ((req_chan.req_type == REQ_PUSH_FRONT) ||
                  (req_chan.req_type == REQ_POP_FRONT)) != rev_ff;
      if (accept) begin
         err_in = 1'b0;
         case (req_chan.req_type) inside
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
               if (is_full) begin
                  err_in = 1'b1;
               end else begin
                  cmd.shift_in   = at_first;
                  cmd.write_tail = !at_first;
                  count_in       = count_ff + COUNT_W'(1);
               end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
               if (is_empty_now) begin
                  err_in = 1'b1;
               end else begin
                  cmd.shift_out = at_first;
                  cmd.drop_tail = !at_first;
                  count_in      = count_ff - COUNT_W'(1);
               end
            end
            REQ_REVERSE: begin
               rev_in = !rev_ff;
            end
            default: begin
               // query and unused codes leave the row, count and direction alone
            end
         endcase
      end
   end

   // Build the row, each cell wired to its neighbours
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] lv, rv;
      logic                   lvalid, rvalid;
      if (i == 0) begin : g_left_edge
         assign lv     = push_word;
         assign lvalid = 1'b1;
      end else begin : g_left_inner
         assign lv     = cell_value[i-1];
         assign lvalid = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_edge
         assign rv     = '0;
         assign rvalid = 1'b0;
      end else begin : g_right_inner
         assign rv     = cell_value[i+1];
         assign rvalid = cell_valid[i+1];
      end
      deqr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .push_word   (push_word),
         .left_value  (lv),
         .left_valid  (lvalid),
         .right_value (rv),
         .right_valid (rvalid),
         .cell_value  (cell_value[i]),
         .cell_valid  (cell_valid[i]),
         .back_part   (back_part[i])
      );
   end

   // Gather the physical first and last words
   always_comb begin
      first_word = cell_valid[0] ? cell_value[0] : '0;
      last_word  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         last_word = last_word | back_part[i];
      end
   end

   // Advance the handshake state
   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         pend_ff      <= pend_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result item from the row as it stands after the request
   always_ff @(posedge clock) begin
      if (load) begin
         front_ff  <= FIELD_W'(rev_ff ? last_word : first_word);
         back_ff   <= FIELD_W'(rev_ff ? first_word : last_word);
         entry_ff  <= ENTRY_COUNT_W'(count_ff);
         empty_ff  <= is_empty_now;
         op_err_ff <= err_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.front_value = front_ff;
   assign rsp_chan.back_value  = back_ff;
   assign rsp_chan.entry_count = entry_ff;
   assign rsp_chan.is_empty    = empty_ff;
   assign rsp_chan.op_error    = op_err_ff;

endmodule

### rtl/deqr_checker.sv
// Port-level checks on the deque's result channel, bound to the top level.
// Depends on deqr_pkg and double_ended_queue_with_reverse.
module deqr_checker import deqr_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [FIELD_W-1:0]       front_value,
   input logic [FIELD_W-1:0]       back_value,
   input logic [ENTRY_COUNT_W-1:0] entry_count,
   input logic                     is_empty,
   input logic                     op_error
);

   // Hold a stalled result item (every field but is_empty)
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_value) &&
      $stable(back_value) && $stable(entry_count) && $stable(op_error))
      else $error("result item changed while stalled");

   // Empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_empty == (entry_count == '0)))
      else $error("is_empty disagrees with entry_count");

   // An empty queue reports zero ends
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_empty |-> (front_value == '0) && (back_value == '0))
      else $error("non-zero end value on an empty queue");

   // Count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (entry_count <= ENTRY_COUNT_W'(DEPTH)))
      else $error("entry_count beyond capacity");

   // A single word is both front and back
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (entry_count == ENTRY_COUNT_W'(1)) |-> (front_value == back_value))
      else $error("front and back differ with one entry");

endmodule

bind double_ended_queue_with_reverse deqr_checker u_deqr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .front_value (rsp_chan.front_value),
   .back_value  (rsp_chan.back_value),
   .entry_count (rsp_chan.entry_count),
   .is_empty    (rsp_chan.is_empty),
   .op_error    (rsp_chan.op_error)
);
